### hw/rtl/redecn_pkg.sv
// ----------------------------------------------------------------------------
// RED ECN marker package
// Shared types, field widths, register indexes and codes for the RED marker
// and its quotient unit.
// ----------------------------------------------------------------------------
package redecn_pkg;

    localparam int FRAC_W     = 16;
    localparam int AVG_W      = 28;
    localparam int CNT_W      = 17;
    localparam int GATE_W     = 3;
    localparam int QLEN_W     = 13;
    localparam int MIN_W      = 12;
    localparam int MAX_W      = 13;
    localparam int PROB_W     = 16;
    localparam int IDLE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W = AVG_W;
    localparam int MUL_B_W = FRAC_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DIV_W  = MAX_W;
    localparam int PB_W   = FRAC_W;
    localparam int STEP_W = $clog2(PB_W + 1);

    localparam logic [FRAC_W:0]  ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [AVG_W-1:0] AVG_MAX = '1;

    localparam logic signed [CNT_W-1:0] COUNT_MAX  = 17'sd65535;
    localparam logic signed [CNT_W-1:0] COUNT_IDLE = '1;

    localparam logic [MIN_W-1:0]  MIN_TH_RST   = 12'd5;
    localparam logic [MAX_W-1:0]  MAX_TH_RST   = 13'd15;
    localparam logic [PROB_W-1:0] MAX_PROB_RST = 16'd6554;
    localparam logic [FRAC_W-1:0] WQ_RST       = 16'd131;
    localparam logic [MAX_W-1:0]  QCAP_RST     = 13'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WQ       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QCAP     = 3'd4;

    localparam logic [1:0] ACT_FORWARD = 2'd0;
    localparam logic [1:0] ACT_MARK    = 2'd1;
    localparam logic [1:0] ACT_DROP    = 2'd2;

    localparam logic [1:0] ECN_ECT1 = 2'd1;
    localparam logic [1:0] ECN_ECT0 = 2'd2;

    typedef struct packed {
        logic [GATE_W-1:0] gate;
        logic              is_ipv4;
        logic [1:0]        ecn_codepoint;
        logic [QLEN_W-1:0] queue_length;
        logic [IDLE_W-1:0] idle_slots;
        logic [FRAC_W-1:0] random_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [AVG_W-1:0] average_queue;
    } out_item_t;

endpackage

### hw/rtl/redecn_div.sv
// ----------------------------------------------------------------------------
// RED marker quotient unit
// Restoring divider that produces one quotient bit per cycle. The caller
// supplies a partial remainder that is already below the divisor.
// ----------------------------------------------------------------------------
module redecn_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [redecn_pkg::DIV_W-1:0] rem_init,
    input  logic [redecn_pkg::PB_W-1:0]  dividend_low,
    input  logic [redecn_pkg::DIV_W-1:0] divisor,
    output logic [redecn_pkg::PB_W-1:0]  quotient,
    output logic                         done
);
    import redecn_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [PB_W-1:0]   quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    shifted;
    logic [DIV_W+1:0]  trial;
    logic              fits;
    logic [DIV_W-1:0]  rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PB_W-1]};
        trial    = {1'b0, shifted} - {2'b00, div_reg};
        fits     = !trial[DIV_W+1];
        rem_next = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(1));
            if (start)
            begin
                rem_reg  <= rem_init;
                quo_reg  <= dividend_low;
                div_reg  <= divisor;
                step_reg <= STEP_W'(PB_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[PB_W-2:0], fits};
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("Partial remainder reached the divisor.");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("Division started while a division was running.");

    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("Done raised outside the end of a division.");

endmodule

### hw/rtl/red_ecn_marker.sv
// ----------------------------------------------------------------------------
// RED ECN marker
// Keeps a single average queue length and a count per gate, and decides for each
// arriving packet whether it is forwarded, marked CE or dropped.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data   (in_item_t)
// out       output     out_valid / out_stall out_data  (out_item_t)
// cfg       input      cfg_write             cfg_index, cfg_data
//
// A transaction updates the average from the queue length when the queue is
// non-empty, and decays it by the idle_slots factor when it is empty, stepping
// through idle_slots up to the position of its highest set bit.
// An average inside the threshold band adds a quotient and up to two more products;
// all products use the single 28 x 17 multiplier, and the quotient the 16-step loop.
// The next transaction is taken in the cycle after the result is registered,
// and the result waits in the output register while out_stall is high.
// Reset sets every gate count to minus one and the average to zero at once.
// ----------------------------------------------------------------------------
module red_ecn_marker #(
    parameter int NUM_GATES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  redecn_pkg::in_item_t                in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output redecn_pkg::out_item_t               out_data,
    input  logic                                cfg_write,
    input  logic [redecn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [redecn_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import redecn_pkg::*;

    localparam int IDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EW_A,
        ST_EW_B,
        ST_EW_C,
        ST_DEC_MR,
        ST_DEC_MF,
        ST_DEC_AVG,
        ST_DEC_W,
        ST_DECIDE,
        ST_PB_START,
        ST_PB_WAIT,
        ST_CP,
        ST_CPW,
        ST_PA,
        ST_PAW,
        ST_EMIT
    } state_t;

    function automatic logic [IDX_W-1:0] gate_index(input logic [GATE_W-1:0] g);
        logic [GATE_W-1:0] v;
        v = g;
        for (int i = 0; i < (1 << GATE_W); i++)
        begin
            if (int'(v) >= NUM_GATES)
            begin
                v = v - GATE_W'(NUM_GATES);
            end
        end
        return IDX_W'(v);
    endfunction

    state_t             state_reg;
    in_item_t           item_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic [MIN_W-1:0]   min_th_reg;
    logic [MAX_W-1:0]   max_th_reg;
    logic [PROB_W-1:0]  max_prob_reg;
    logic [FRAC_W-1:0]  wq_reg;
    logic [MAX_W-1:0]   qcap_reg;

    logic [AVG_W-1:0]   avg_reg;
    logic [AVG_W:0]     acc_reg;
    logic [FRAC_W:0]    r_reg;
    logic [FRAC_W:0]    f_reg;
    logic [IDLE_W-1:0]  idle_reg;
    logic               first_reg;
    logic [FRAC_W-1:0]  cnt_reg;
    logic [FRAC_W:0]    d_reg;
    logic [1:0]         act_reg;

    logic [CNT_W-1:0]   cnt_mem [NUM_GATES];
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic [NUM_GATES-1:0] cnt_vld_reg;
    logic               rd_vld_reg;

    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    logic               accept;
    logic               ect;
    logic               drop;
    logic               above;
    logic               in_band;
    logic [MAX_W-1:0]   cap;
    logic [AVG_W-1:0]   lo;
    logic [AVG_W:0]     hi;
    logic signed [CNT_W-1:0] cnt_cur;
    logic signed [CNT_W-1:0] cnt_sum;
    logic [FRAC_W-1:0]  cnt_inc;
    logic [FRAC_W:0]    f_eff;
    logic [AVG_W+1:0]   sum_ew;
    logic [AVG_W-1:0]   avg_sat;
    logic [FRAC_W:0]    d_next;
    logic               pa_sat;
    logic               mark_pa;
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_wdata;

    logic               div_start;
    logic [DIV_W-1:0]   div_rem_init;
    logic [DIV_W-1:0]   div_divisor;
    logic [PB_W-1:0]    div_quot;
    logic               div_done;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign idx_next = gate_index(in_data.gate);

    always_comb
    begin
        ect     = item_reg.is_ipv4 &&
                  (item_reg.ecn_codepoint == ECN_ECT1 || item_reg.ecn_codepoint == ECN_ECT0);
        cap     = (qcap_reg > max_th_reg) ? qcap_reg : max_th_reg;
        drop    = item_reg.queue_length >= cap;
        lo      = {min_th_reg, {FRAC_W{1'b0}}};
        hi      = {max_th_reg, {FRAC_W{1'b0}}};
        above   = {1'b0, avg_reg} >= hi;
        in_band = (avg_reg >= lo) && !above;

        cnt_cur = rd_vld_reg ? signed'(rd_cnt_reg) : COUNT_IDLE;
        cnt_sum = (cnt_cur < COUNT_MAX) ? cnt_cur + 17'sd1 : cnt_cur;
        cnt_inc = cnt_sum[FRAC_W-1:0];

        f_eff   = first_reg ? f_reg : prod_reg[2*FRAC_W:FRAC_W];
        sum_ew  = {1'b0, acc_reg} + {1'b0, prod_reg[AVG_W:0]};
        avg_sat = (sum_ew[AVG_W+1:AVG_W] != 2'b00) ? AVG_MAX : sum_ew[AVG_W-1:0];

        d_next  = ONE_Q16 - {1'b0, prod_reg[FRAC_W-1:0]};
        pa_sat  = prod_reg[PROD_W-1:FRAC_W] != '0;
        mark_pa = prod_reg[2*FRAC_W+1:0] <= {2'b00, div_quot, {FRAC_W{1'b0}}};
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EW_A:
            begin
                mul_a = avg_reg;
                mul_b = ONE_Q16 - {1'b0, wq_reg};
            end
            ST_EW_B:
            begin
                mul_a = MUL_A_W'(item_reg.queue_length);
                mul_b = MUL_B_W'(wq_reg);
            end
            ST_DEC_MR:
            begin
                mul_a = MUL_A_W'(r_reg);
                mul_b = f_eff;
            end
            ST_DEC_MF:
            begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = f_reg;
            end
            ST_DEC_AVG:
            begin
                mul_a = avg_reg;
                mul_b = r_reg;
            end
            ST_DECIDE:
            begin
                mul_a = avg_reg - lo;
                mul_b = MUL_B_W'(max_prob_reg);
            end
            ST_CP:
            begin
                mul_a = MUL_A_W'(cnt_reg);
                mul_b = MUL_B_W'(div_quot);
            end
            ST_PA:
            begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'(item_reg.random_word) + 17'd1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        case (state_reg)
            ST_DECIDE:
            begin
                cnt_we    = !(ect && !drop && in_band);
                cnt_wdata = (drop || (ect && above)) ? '0 : COUNT_IDLE;
            end
            ST_CPW:
            begin
                cnt_we    = pa_sat;
                cnt_wdata = '0;
            end
            ST_PAW:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = mark_pa ? '0 : {1'b0, cnt_reg};
            end
            default:
            begin
                cnt_we    = 1'b0;
                cnt_wdata = '0;
            end
        endcase
    end

    assign div_start    = (state_reg == ST_PB_START);
    assign div_rem_init = DIV_W'(prod_reg[MUL_A_W+FRAC_W-1:2*FRAC_W]);
    assign div_divisor  = max_th_reg - {1'b0, min_th_reg};

    redecn_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .rem_init     (div_rem_init),
        .dividend_low (prod_reg[2*FRAC_W-1:FRAC_W]),
        .divisor      (div_divisor),
        .quotient     (div_quot),
        .done         (div_done)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cnt_we)
        begin
            cnt_mem[idx_reg] <= cnt_wdata;
        end
        if (accept)
        begin
            rd_cnt_reg <= cnt_mem[idx_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            idx_reg       <= '0;
            min_th_reg    <= MIN_TH_RST;
            max_th_reg    <= MAX_TH_RST;
            max_prob_reg  <= MAX_PROB_RST;
            wq_reg        <= WQ_RST;
            qcap_reg      <= QCAP_RST;
            avg_reg       <= '0;
            acc_reg       <= '0;
            r_reg         <= '0;
            f_reg         <= '0;
            idle_reg      <= '0;
            first_reg     <= 1'b0;
            cnt_reg       <= '0;
            d_reg         <= '0;
            act_reg       <= ACT_FORWARD;
            cnt_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MIN_TH:   min_th_reg   <= cfg_data[MIN_W-1:0];
                    CFG_MAX_TH:   max_th_reg   <= cfg_data[MAX_W-1:0];
                    CFG_MAX_PROB: max_prob_reg <= cfg_data[PROB_W-1:0];
                    CFG_WQ:       wq_reg       <= cfg_data[FRAC_W-1:0];
                    CFG_QCAP:     qcap_reg     <= cfg_data[MAX_W-1:0];
                    default:      ;
                endcase
            end

            if (cnt_we)
            begin
                cnt_vld_reg[idx_reg] <= 1'b1;
            end

            if (!out_stall && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg   <= in_data;
                        idx_reg    <= idx_next;
                        rd_vld_reg <= cnt_vld_reg[idx_next];
                        r_reg      <= ONE_Q16;
                        f_reg      <= ONE_Q16 - {1'b0, wq_reg};
                        idle_reg   <= in_data.idle_slots;
                        first_reg  <= 1'b1;
                        state_reg  <= (in_data.queue_length != '0) ? ST_EW_A : ST_DEC_MR;
                    end
                end
                ST_EW_A:
                begin
                    state_reg <= ST_EW_B;
                end
                ST_EW_B:
                begin
                    acc_reg   <= prod_reg[PROD_W-1:FRAC_W];
                    state_reg <= ST_EW_C;
                end
                ST_EW_C:
                begin
                    avg_reg   <= avg_sat;
                    state_reg <= ST_DECIDE;
                end
                ST_DEC_MR:
                begin
                    if (idle_reg == '0)
                    begin
                        state_reg <= ST_DEC_AVG;
                    end
                    else
                    begin
                        f_reg     <= f_eff;
                        first_reg <= 1'b0;
                        state_reg <= ST_DEC_MF;
                    end
                end
                ST_DEC_MF:
                begin
                    if (idle_reg[0])
                    begin
                        r_reg <= prod_reg[2*FRAC_W:FRAC_W];
                    end
                    idle_reg  <= idle_reg >> 1;
                    state_reg <= ST_DEC_MR;
                end
                ST_DEC_AVG:
                begin
                    state_reg <= ST_DEC_W;
                end
                ST_DEC_W:
                begin
                    avg_reg   <= prod_reg[MUL_A_W+FRAC_W-1:FRAC_W];
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (ect && !drop && in_band)
                    begin
                        cnt_reg   <= cnt_inc;
                        state_reg <= ST_PB_START;
                    end
                    else
                    begin
                        if (drop)
                        begin
                            act_reg <= ACT_DROP;
                        end
                        else if (ect && above)
                        begin
                            act_reg <= ACT_MARK;
                        end
                        else
                        begin
                            act_reg <= ACT_FORWARD;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_PB_START:
                begin
                    state_reg <= ST_PB_WAIT;
                end
                ST_PB_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_CP;
                    end
                end
                ST_CP:
                begin
                    state_reg <= ST_CPW;
                end
                ST_CPW:
                begin
                    if (pa_sat)
                    begin
                        act_reg   <= ACT_MARK;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        d_reg     <= d_next;
                        state_reg <= ST_PA;
                    end
                end
                ST_PA:
                begin
                    state_reg <= ST_PAW;
                end
                ST_PAW:
                begin
                    act_reg   <= mark_pa ? ACT_MARK : ACT_FORWARD;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.action        <= act_reg;
                        out_data_reg.average_queue <= avg_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("Accepted transaction did not start the sequencer.");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_PB_WAIT)
        else $error("Quotient finished while the sequencer was not waiting for it.");

    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |=> $stable(avg_reg))
        else $error("Average changed while no transaction was in progress.");

    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && out_stall) |=> state_reg == ST_EMIT)
        else $error("Result left the sequencer while the output register was full.");

endmodule
